// ===== design/ssef_pkg.sv =====
// Shared types and constants for the star skeleton extremity finder.
package ssef_pkg;

    // Largest frame dimension that is honored; larger sizes are clamped to it.
    localparam int unsigned MAX_DIM = 2048;
    localparam int unsigned DIM_W   = 13;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CENTER_X     = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y     = 2'd1;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd3;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [14:0] center_x_q4;
        logic [14:0] center_y_q4;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
    } t_cfg;

    // Beat handed from the distance stage to the tracking stage.
    typedef struct packed {
        logic        valid;
        logic        fg;
        logic        left;
        logic        last;
        logic [29:0] dx2;
        logic [29:0] dy2;
        logic [14:0] xq;
        logic [14:0] yq;
        logic [10:0] row;
    } t_dist_beat;

    // Point in Q.4, column and row.
    typedef struct packed {
        logic [14:0] x;
        logic [14:0] y;
    } t_point;

endpackage

// ===== design/ssef_dist.sv =====
// Input register, pixel qualification and squared offset products.
module ssef_dist (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssef_pkg::t_cfg       i_cfg,
    input  logic                 i_en,
    input  logic                 i_in_valid,
    input  logic [7:0]           i_pixel,
    input  logic [10:0]          i_col,
    input  logic [10:0]          i_row,
    input  logic                 i_frame_end,
    output ssef_pkg::t_dist_beat o_beat
);
    import ssef_pkg::*;

    logic        r_valid;
    logic [7:0]  r_pixel;
    logic [10:0] r_col;
    logic [10:0] r_row;
    logic        r_last;

    t_dist_beat  r_beat;
    t_dist_beat  n_beat;

    logic [DIM_W-1:0] w_clamp;
    logic [DIM_W-1:0] h_clamp;
    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic [14:0]      xq;
    logic [14:0]      yq;
    logic [14:0]      dx;
    logic [14:0]      dy;

    // Input register; it moves whenever the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_in_valid;
        end
        if (i_en) begin
            r_pixel <= i_pixel;
            r_col   <= i_col;
            r_row   <= i_row;
            r_last  <= i_frame_end;
        end
    end

    // Clamp frame sizes, qualify the pixel, pick its half and square its offsets.
    always_comb begin
        w_clamp = ({1'b0, i_cfg.frame_width} > DIM_W'(MAX_DIM)) ?
                  DIM_W'(MAX_DIM) : {1'b0, i_cfg.frame_width};
        h_clamp = ({1'b0, i_cfg.frame_height} > DIM_W'(MAX_DIM)) ?
                  DIM_W'(MAX_DIM) : {1'b0, i_cfg.frame_height};
        col_ext = {2'b00, r_col};
        row_ext = {2'b00, r_row};
        xq      = {r_col, 4'b0000};
        yq      = {r_row, 4'b0000};
        dx      = (xq >= i_cfg.center_x_q4) ? (xq - i_cfg.center_x_q4)
                                            : (i_cfg.center_x_q4 - xq);
        dy      = (yq >= i_cfg.center_y_q4) ? (yq - i_cfg.center_y_q4)
                                            : (i_cfg.center_y_q4 - yq);

        n_beat       = r_beat;
        n_beat.valid = r_valid;
        n_beat.fg    = (r_pixel != 8'd0) && (col_ext < w_clamp) &&
                       (row_ext < h_clamp) && (row_ext >= (h_clamp >> 1));
        n_beat.left  = col_ext < (w_clamp >> 1);
        n_beat.last  = r_last;
        n_beat.dx2   = 30'(dx * dx);
        n_beat.dy2   = 30'(dy * dy);
        n_beat.xq    = xq;
        n_beat.yq    = yq;
        n_beat.row   = r_row;
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat.valid <= n_beat.valid;
        end
        if (i_en) begin
            r_beat.fg   <= n_beat.fg;
            r_beat.left <= n_beat.left;
            r_beat.last <= n_beat.last;
            r_beat.dx2  <= n_beat.dx2;
            r_beat.dy2  <= n_beat.dy2;
            r_beat.xq   <= n_beat.xq;
            r_beat.yq   <= n_beat.yq;
            r_beat.row  <= n_beat.row;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== design/ssef_track.sv =====
// Farthest point tracking per half, lowest row, and the result register.
module ssef_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssef_pkg::t_cfg       i_cfg,
    input  ssef_pkg::t_dist_beat i_beat,
    output logic                 o_en,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [30:0]          o_left_dist_sq,
    output logic [30:0]          o_right_dist_sq,
    output logic [14:0]          o_left_far_x,
    output logic [14:0]          o_left_far_y,
    output logic [14:0]          o_right_far_x,
    output logic [14:0]          o_right_far_y,
    output logic signed [15:0]   o_ground_offset
);
    import ssef_pkg::*;

    logic [30:0] r_best_left;
    logic [30:0] r_best_right;
    t_point      r_left_point;
    t_point      r_right_point;
    logic [10:0] r_lowest_row;

    logic [30:0] n_best_left;
    logic [30:0] n_best_right;
    t_point      n_left_point;
    t_point      n_right_point;
    logic [10:0] n_lowest_row;

    logic        r_out_valid;
    logic [30:0] r_left_dist_sq;
    logic [30:0] r_right_dist_sq;
    t_point      r_left_far;
    t_point      r_right_far;
    logic [15:0] r_ground_offset;

    logic [30:0] sq_dist;
    logic        take;
    logic        load;
    t_point      new_point;

    // Average of the kept point and the new one, truncated.
    function automatic t_point avg_point(input t_point a, input t_point b);
        logic [15:0] sx;
        logic [15:0] sy;
        t_point      res;
        sx    = {1'b0, a.x} + {1'b0, b.x};
        sy    = {1'b0, a.y} + {1'b0, b.y};
        res.x = sx[15:1];
        res.y = sy[15:1];
        return res;
    endfunction

    // The pipeline halts only when a result is due and the last one still waits.
    assign o_en = !(i_beat.valid && i_beat.last && r_out_valid && i_out_stall);
    assign take = i_beat.valid && o_en;
    assign load = take && i_beat.last;

    // Next tracking state, including the current pixel.
    always_comb begin
        sq_dist      = {1'b0, i_beat.dx2} + {1'b0, i_beat.dy2};
        new_point.x  = i_beat.xq;
        new_point.y  = i_beat.yq;
        n_best_left  = r_best_left;
        n_best_right = r_best_right;
        n_left_point = r_left_point;
        n_right_point = r_right_point;
        n_lowest_row = r_lowest_row;
        if (i_beat.fg) begin
            if (i_beat.left) begin
                if (sq_dist > r_best_left) begin
                    n_best_left  = sq_dist;
                    n_left_point = new_point;
                end else if (sq_dist == r_best_left) begin
                    n_left_point = avg_point(r_left_point, new_point);
                end
            end else begin
                if (sq_dist > r_best_right) begin
                    n_best_right  = sq_dist;
                    n_right_point = new_point;
                end else if (sq_dist == r_best_right) begin
                    n_right_point = avg_point(r_right_point, new_point);
                end
            end
            if (i_beat.row > r_lowest_row) begin
                n_lowest_row = i_beat.row;
            end
        end
    end

    // Tracking state; cleared after the frame's last beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load) begin
            r_best_left   <= '0;
            r_best_right  <= '0;
            r_left_point  <= '0;
            r_right_point <= '0;
            r_lowest_row  <= '0;
        end else if (take) begin
            r_best_left   <= n_best_left;
            r_best_right  <= n_best_right;
            r_left_point  <= n_left_point;
            r_right_point <= n_right_point;
            r_lowest_row  <= n_lowest_row;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_left_dist_sq  <= n_best_left;
            r_right_dist_sq <= n_best_right;
            r_left_far      <= n_left_point;
            r_right_far     <= n_right_point;
            r_ground_offset <= {1'b0, n_lowest_row, 4'b0000} -
                               {1'b0, i_cfg.center_y_q4};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_dist_sq  = r_left_dist_sq;
    assign o_right_dist_sq = r_right_dist_sq;
    assign o_left_far_x    = r_left_far.x;
    assign o_left_far_y    = r_left_far.y;
    assign o_right_far_x   = r_right_far.x;
    assign o_right_far_y   = r_right_far.y;
    assign o_ground_offset = r_ground_offset;

    // A halt only happens while a result is waiting.
    a_halt_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |-> r_out_valid)
        else $error("pipeline halted without a pending result");

    // A held frame end leaves the tracking state alone.
    a_halt_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> (r_best_left == $past(r_best_left)) &&
                  (r_best_right == $past(r_best_right)) &&
                  (r_lowest_row == $past(r_lowest_row)))
        else $error("tracking state changed while halted");

    // Emitting a result clears the tracking state.
    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_best_left == '0) && (r_best_right == '0) &&
                 (r_lowest_row == '0) && r_out_valid)
        else $error("state not cleared after frame end");

endmodule

// ===== design/star_skeleton_extremity_finder.sv =====
// Top level of the star skeleton extremity finder.
// Pixels of a frame enter in raster order, one beat per clock while
// o_in_stall is low; the pipeline adds no bubbles: every beat runs through
// an input register, a squared-offset multiply stage and a tracking stage,
// and the result register is loaded when the tracking stage takes the
// frame_end beat. The only throughput limit is the single result register:
// a frame_end beat waits in the tracking stage (and the input stalls) only
// while the previous frame's result has not yet been taken.
// Distances are squared and in Q.8, points and ground offset are in Q.4.
// Configuration may be written only while no frame is in flight.
module star_skeleton_extremity_finder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_pixel,
    input  logic [10:0]        i_col,
    input  logic [10:0]        i_row,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [30:0]        o_left_dist_sq,
    output logic [30:0]        o_right_dist_sq,
    output logic [14:0]        o_left_far_x,
    output logic [14:0]        o_left_far_y,
    output logic [14:0]        o_right_far_x,
    output logic [14:0]        o_right_far_y,
    output logic signed [15:0] o_ground_offset
);
    import ssef_pkg::*;

    t_cfg       r_cfg;
    t_dist_beat dist_beat;
    logic       en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x_q4  <= 15'd0;
            r_cfg.center_y_q4  <= 15'd0;
            r_cfg.frame_width  <= 12'd640;
            r_cfg.frame_height <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:     r_cfg.center_x_q4  <= i_cfg_data;
                CFG_CENTER_Y:     r_cfg.center_y_q4  <= i_cfg_data;
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[11:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = !en;

    // Distance stage.
    ssef_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_en        (en),
        .i_in_valid  (i_in_valid),
        .i_pixel     (i_pixel),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_frame_end (i_frame_end),
        .o_beat      (dist_beat)
    );

    // Tracking stage and result register.
    ssef_track u_track (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_beat          (dist_beat),
        .o_en            (en),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_left_dist_sq  (o_left_dist_sq),
        .o_right_dist_sq (o_right_dist_sq),
        .o_left_far_x    (o_left_far_x),
        .o_left_far_y    (o_left_far_y),
        .o_right_far_x   (o_right_far_x),
        .o_right_far_y   (o_right_far_y),
        .o_ground_offset (o_ground_offset)
    );

endmodule
